/* hdl/tlss_pkg.sv */
package tlss_pkg;

  localparam int unsigned TileSizeDef  = 16;
  localparam int unsigned MaxLightsDef = 16;

  // Configuration register indexes
  localparam logic [1:0] RegScreenLeft = 2'd0;
  localparam logic [1:0] RegScreenTop  = 2'd1;
  localparam logic [1:0] RegLightCount = 2'd2;

  localparam logic CmdLoad   = 1'b0;
  localparam logic CmdSample = 1'b1;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [11:0]        radius;
    logic [8:0]         strength;
  } light_t;

  typedef struct packed {
    logic [7:0] span_row;
    logic [7:0] span_start;
    logic [8:0] span_length;
    logic [7:0] span_shade;
    logic       last;
  } span_t;

  typedef struct packed {
    logic       cmd;
    logic [3:0] light_index;
    logic signed [15:0] light_x;
    logic signed [15:0] light_y;
    logic [11:0] light_radius;
    logic [8:0]  light_strength;
    logic [7:0]  tile_col;
    logic [7:0]  tile_row;
    logic        row_end;
  } item_t;

  // Light cell control handed down the chain
  typedef struct packed {
    logic start;
    logic sel;
  } cell_ctl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LIGHT,
    ST_WAIT,
    ST_MERGE,
    ST_OUT
  } state_e;

endpackage

/* hdl/tlss_if.sv */
interface tlss_in_if;
  logic            valid;
  logic            ready;
  tlss_pkg::item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface tlss_out_if;
  logic            valid;
  logic            ready;
  tlss_pkg::span_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface tlss_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] wdata;
  modport source (output valid, output index, output wdata, input ready);
  modport sink (input valid, input index, input wdata, output ready);
endinterface

/* hdl/tlss_root_cell.sv */
// One step of the restoring square root: two radicand bits per cell.
module tlss_root_cell (
  input  logic        clk_i,
  input  logic [65:0] rem_i,
  input  logic [32:0] root_i,
  input  logic [1:0]  bits_i,
  output logic [65:0] rem_o,
  output logic [32:0] root_o
);
  logic [65:0] trial;
  logic [65:0] shifted;
  logic [65:0] rem_d;
  logic [32:0] root_d;

  always_comb begin
    shifted = {rem_i[63:0], bits_i};
    trial   = {31'd0, root_i, 2'b01};
    if (shifted >= trial) begin
      rem_d  = shifted - trial;
      root_d = {root_i[31:0], 1'b1};
    end else begin
      rem_d  = shifted;
      root_d = {root_i[31:0], 1'b0};
    end
  end

  // Hand the partial result to the next cell
  always_ff @(posedge clk_i) begin
    rem_o  <= rem_d;
    root_o <= root_d;
  end
endmodule

/* hdl/tlss_div_cell.sv */
// One step of the restoring divide: one quotient bit per cell.
module tlss_div_cell (
  input  logic        clk_i,
  input  logic [16:0] rem_i,
  input  logic [32:0] num_i,
  input  logic [15:0] den_i,
  input  logic [16:0] quo_i,
  output logic [16:0] rem_o,
  output logic [32:0] num_o,
  output logic [15:0] den_o,
  output logic [16:0] quo_o
);
  logic [17:0] sh;
  logic [16:0] rem_d;
  logic        q;

  always_comb begin
    sh = {rem_i, num_i[32]};
    q  = (sh >= {2'b00, den_i});
    rem_d = q ? 17'(sh - {2'b00, den_i}) : sh[16:0];
  end

  // Advance one bit down the chain
  always_ff @(posedge clk_i) begin
    rem_o <= rem_d;
    num_o <= {num_i[31:0], 1'b0};
    den_o <= den_i;
    quo_o <= {quo_i[15:0], q};
  end
endmodule

/* hdl/tile_light_shade_span_merge_unit.sv */
// Tile light shading with span merging.
// Channels: in_if carries load words (cmd 0, write a light table entry) and
// sample words (cmd 1, one tile in raster order); out_if carries span words;
// cfg_if writes screen_left, screen_top and light_count by index 0..2.
// A load is taken while idle and loads can follow back to back. A sample
// walks the active lights one at a time: for each light it sets up its
// operands and then waits while they go through a chain of 33 square root
// cells and 17 divide cells. It then emits up to two spans.
// One item is worked at a time; in_if.ready is low while a sample is in
// flight or a span waits. When the receiver stalls, the span word holds in
// the output register and the block waits. Reset clears the open run, the
// configuration registers and the handshakes; the light table is undefined until loaded.
module tile_light_shade_span_merge_unit #(
  parameter int unsigned TILE_SIZE  = tlss_pkg::TileSizeDef,
  parameter int unsigned MAX_LIGHTS = tlss_pkg::MaxLightsDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  tlss_in_if.sink    in_if,
  tlss_out_if.source out_if,
  tlss_cfg_if.sink   cfg_if
);
  localparam int unsigned IdxW = (MAX_LIGHTS > 1) ? $clog2(MAX_LIGHTS) : 1;
  localparam int unsigned CntW = $clog2(MAX_LIGHTS + 1);
  localparam int unsigned RootN = 33;
  localparam int unsigned DivN  = 17;
  localparam int unsigned LatN  = RootN + DivN + 2;
  localparam int unsigned LatW  = $clog2(LatN + 1);
  localparam logic signed [31:0] HalfQ  = 32'(TILE_SIZE * 8);

  tlss_pkg::state_e state_q, state_d;
  tlss_pkg::light_t tbl_q [MAX_LIGHTS];

  logic signed [15:0] left_q, top_q;
  logic [4:0]         count_q;
  tlss_pkg::item_t    item_q;
  logic [CntW-1:0]    nact;
  logic [CntW-1:0]    li_q;
  logic [LatW-1:0]    lat_q;
  logic [20:0]        sum_q;
  logic signed [31:0] cx_q, cy_q;

  // Per-light operands
  logic signed [33:0] dx_q, dy_q;
  logic [63:0]        dsq_q;
  logic [31:0]        lim_q;
  logic [8:0]         str_q;
  logic               inside_q;
  logic [1:0]         ph_q;

  // Run state
  logic [7:0] run_row_q, run_start_q, run_shade_q;
  logic [8:0] run_len_q;
  logic [7:0] shade_q;
  logic       ovalid_q;
  tlss_pkg::span_t odata_q;
  logic       ev_q;

  assign nact = (32'(count_q) > 32'(MAX_LIGHTS)) ? CntW'(MAX_LIGHTS) : CntW'(count_q);

  // Configuration writes
  assign cfg_if.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q  <= '0;
      top_q   <= '0;
      count_q <= '0;
    end else if (cfg_if.valid) begin
      unique case (cfg_if.index)
        tlss_pkg::RegScreenLeft: left_q  <= cfg_if.wdata;
        tlss_pkg::RegScreenTop:  top_q   <= cfg_if.wdata;
        tlss_pkg::RegLightCount: count_q <= cfg_if.wdata[4:0];
        default: ;
      endcase
    end
  end

  assign in_if.ready = (state_q == tlss_pkg::ST_IDLE) && !ovalid_q;
  wire in_acc = in_if.valid && in_if.ready;

  // Cell chain: square root then divide
  logic [65:0] rem_c  [RootN+1];
  logic [32:0] root_c [RootN+1];
  logic [127:0] rad;
  // Radicand is the squared distance scaled by 2^32, in the top 64 bits
  assign rad = {dsq_q[31:0], 96'd0};
  assign rem_c[0]  = '0;
  assign root_c[0] = '0;
  // Radicand bits travel with the word: keep a delayed copy per cell
  logic [127:0] rad_c [RootN+1];
  assign rad_c[0] = rad >> 2;
  for (genvar g = 0; g < RootN; g++) begin : g_root
    logic [1:0] b;
    assign b = (g == 0) ? 2'b00 : rad_c[g][127:126];
    tlss_root_cell u_cell (
      .clk_i, .rem_i(rem_c[g]), .root_i(root_c[g]), .bits_i(b),
      .rem_o(rem_c[g+1]), .root_o(root_c[g+1]));
    always_ff @(posedge clk_i) begin
      rad_c[g+1] <= (g == 0) ? rad : {rad_c[g][125:0], 2'b00};
    end
  end

  logic [31:0] lim_c [RootN+1];
  assign lim_c[0] = lim_q;
  for (genvar g = 0; g < RootN; g++) begin : g_lim
    always_ff @(posedge clk_i) lim_c[g+1] <= lim_c[g];
  end

  logic [16:0] drem [DivN+1];
  logic [32:0] dnum [DivN+1];
  logic [15:0] dden [DivN+1];
  logic [16:0] dquo [DivN+1];
  // root <= 2^16 * lim for a light that counts, so the quotient fits 17 bits
  // and the top 16 bits of root are already below lim: start the remainder
  // with them and shift the low 17 bits through the chain.
  assign drem[0] = {1'b0, root_c[RootN][32:17]};
  assign dnum[0] = {root_c[RootN][16:0], 16'd0};
  assign dden[0] = lim_c[RootN][15:0];
  assign dquo[0] = '0;
  for (genvar g = 0; g < DivN; g++) begin : g_div
    tlss_div_cell u_cell (
      .clk_i, .rem_i(drem[g]), .num_i(dnum[g]), .den_i(dden[g]), .quo_i(dquo[g]),
      .rem_o(drem[g+1]), .num_o(dnum[g+1]), .den_o(dden[g+1]), .quo_o(dquo[g+1]));
  end

  logic [16:0] ratio;
  assign ratio = (dquo[DivN] > 17'd65536) ? 17'd65536 : dquo[DivN];
  logic [26:0] prod;
  assign prod = 27'(17'd65536 - ratio) * 27'(str_q) + 27'd128;

  tlss_pkg::light_t cur;
  assign cur = tbl_q[li_q[IdxW-1:0]];

  // Sequencer state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tlss_pkg::ST_IDLE:
        if (in_acc && in_if.data.cmd == tlss_pkg::CmdSample) begin
          state_d = tlss_pkg::ST_LIGHT;
        end
      tlss_pkg::ST_LIGHT:
        if (li_q == nact) state_d = tlss_pkg::ST_MERGE;
        else if (ph_q == 2'd2) state_d = tlss_pkg::ST_WAIT;
      tlss_pkg::ST_WAIT:
        if (lat_q == LatW'(LatN)) state_d = tlss_pkg::ST_LIGHT;
      tlss_pkg::ST_MERGE: state_d = tlss_pkg::ST_OUT;
      tlss_pkg::ST_OUT:
        if (!ovalid_q && !ev_q) state_d = tlss_pkg::ST_IDLE;
      default: state_d = tlss_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= tlss_pkg::ST_IDLE;
    else state_q <= state_d;
  end

  // Load the light table
  always_ff @(posedge clk_i) begin
    if (in_acc && in_if.data.cmd == tlss_pkg::CmdLoad &&
        32'(in_if.data.light_index) < 32'(MAX_LIGHTS)) begin
      tbl_q[in_if.data.light_index[IdxW-1:0]] <= '{x: in_if.data.light_x,
        y: in_if.data.light_y, radius: in_if.data.light_radius,
        strength: in_if.data.light_strength};
    end
  end

  // Per-light datapath and accumulate
  logic [20:0] sum_add;
  assign sum_add = sum_q + 21'(prod[26:8]);
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      li_q  <= '0;
      ph_q  <= '0;
      lat_q <= '0;
      sum_q <= '0;
    end else begin
      if (in_acc) begin
        item_q <= in_if.data;
        cx_q <= (32'(left_q) + 32'(signed'({1'b0, in_if.data.tile_col})) *
                 32'(TILE_SIZE)) * 16 + HalfQ;
        cy_q <= (32'(top_q) + 32'(signed'({1'b0, in_if.data.tile_row})) *
                 32'(TILE_SIZE)) * 16 + HalfQ;
        li_q  <= '0;
        ph_q  <= '0;
        sum_q <= '0;
      end
      if (state_q == tlss_pkg::ST_LIGHT && li_q != nact) begin
        ph_q <= ph_q + 2'd1;
        if (ph_q == 2'd0) begin
          dx_q  <= 34'(cx_q) - 34'(cur.x) * 34'sd16;
          dy_q  <= 34'(cy_q) - 34'(cur.y) * 34'sd16;
          lim_q <= 32'(cur.radius) * 32'd16;
          str_q <= cur.strength;
        end else if (ph_q == 2'd1) begin
          dsq_q <= 64'(dx_q * dx_q) + 64'(dy_q * dy_q);
        end else begin
          inside_q <= (cur.radius != 12'd0) && (dsq_q <= 64'(lim_q) * 64'(lim_q));
          lat_q <= '0;
          ph_q  <= '0;
        end
      end
      if (state_q == tlss_pkg::ST_WAIT) begin
        lat_q <= lat_q + LatW'(1);
        if (lat_q == LatW'(LatN)) begin
          if (inside_q) sum_q <= sum_add;
          li_q <= li_q + CntW'(1);
        end
      end
    end
  end

  // Clamp and round the shade
  logic [17:0] lum;
  logic [25:0] shp;
  assign lum = (sum_q > 21'd65536) ? 18'd65536 : sum_q[17:0];
  assign shp = 26'(lum) * 26'd255 + 26'd32768;

  // Span merge and output register
  logic stale, brk;
  assign stale = (run_len_q != 9'd0) &&
                 (item_q.tile_col == 8'd0 || item_q.tile_row != run_row_q);
  assign brk = (run_len_q != 9'd0) && !stale &&
               (shade_q != run_shade_q || run_len_q >= 9'd256);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_row_q <= '0; run_start_q <= '0; run_len_q <= '0; run_shade_q <= '0;
      ovalid_q <= 1'b0; ev_q <= 1'b0; shade_q <= '0;
    end else begin
      if (out_if.ready && ovalid_q) ovalid_q <= 1'b0;
      if (state_q == tlss_pkg::ST_MERGE) begin
        shade_q <= shp[23:16];
      end
      if (state_q == tlss_pkg::ST_MERGE) ev_q <= 1'b1;
      if (state_q == tlss_pkg::ST_OUT && ev_q && !ovalid_q) begin
        // Step 1: close a stale, changed or full run and open a new one, else extend
        if (stale || brk) begin
          ovalid_q <= 1'b1;
          odata_q  <= '{span_row: run_row_q, span_start: run_start_q,
                        span_length: run_len_q, span_shade: run_shade_q, last: stale};
        end
        if (run_len_q == 9'd0 || stale || brk) begin
          run_row_q <= item_q.tile_row; run_start_q <= item_q.tile_col;
          run_len_q <= 9'd1; run_shade_q <= shade_q;
        end else begin
          run_len_q <= run_len_q + 9'd1;
        end
        ev_q <= 1'b0;
      end
      if (state_q == tlss_pkg::ST_OUT && !ev_q && !ovalid_q && item_q.row_end) begin
        ovalid_q <= 1'b1;
        odata_q  <= '{span_row: run_row_q, span_start: run_start_q,
                      span_length: run_len_q, span_shade: run_shade_q, last: 1'b1};
        run_len_q <= '0;
      end
    end
  end

  assign out_if.valid = ovalid_q;
  assign out_if.data  = odata_q;

  // Row end leaves no open run once the block is idle again
  a_rowend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tlss_pkg::ST_OUT && state_d == tlss_pkg::ST_IDLE && item_q.row_end)
    |=> run_len_q == 9'd0) else $error("open run after row end");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != tlss_pkg::ST_IDLE) |-> !in_if.ready) else $error("ready while busy");
  a_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tlss_pkg::ST_IDLE && $past(state_q == tlss_pkg::ST_IDLE && !in_acc))
    |-> $stable(sum_q))
    else $error("sum moved while idle");
endmodule

/* test/tb_tile_light_shade_span_merge_unit.sv */
`timescale 1ns / 100ps

module tb_tile_light_shade_span_merge_unit;

  localparam int TileSz     = 16;
  localparam int NumLights  = 16;
  localparam int SettleCyc  = 1000;
  localparam int WatchLimit = 50000;

  // Predicts the spans of the block and checks the words that come out
  class span_scoreboard;
    tlss_pkg::light_t   lights[NumLights];
    logic signed [15:0] left_px;
    logic signed [15:0] top_px;
    logic [4:0]         active_cnt;
    logic [7:0]         open_row;
    logic [7:0]         open_start;
    logic [8:0]         open_len;
    logic [7:0]         open_shade;
    tlss_pkg::span_t    spans_due[$];
    int                 errors;

    function new();
      foreach (lights[i]) lights[i] = '0;
      left_px = 0;
      top_px = 0;
      active_cnt = 0;
      open_row = 0;
      open_start = 0;
      open_len = 0;
      open_shade = 0;
      errors = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [15:0] val);
      case (idx)
        tlss_pkg::RegScreenLeft: left_px = val;
        tlss_pkg::RegScreenTop: top_px = val;
        tlss_pkg::RegLightCount: active_cnt = val[4:0];
        default: ;
      endcase
    endfunction

    function longint unsigned int_sqrt(longint unsigned n);
      longint unsigned res;
      longint unsigned bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv >>= 2;
      while (bitv != 0) begin
        if (n >= res + bitv) begin
          n -= res + bitv;
          res = (res >> 1) + bitv;
        end else begin
          res >>= 1;
        end
        bitv >>= 2;
      end
      return res;
    endfunction

    // Sum the light falloff at the tile centre, clamp and round to a byte
    function logic [7:0] tile_shade(logic [7:0] col, logic [7:0] row);
      longint cx, cy, dx, dy;
      longint unsigned dist2, lim, root, ratio, lum;
      int n;
      cx = (longint'(left_px) + longint'(col) * TileSz) * 16 + TileSz * 8;
      cy = (longint'(top_px) + longint'(row) * TileSz) * 16 + TileSz * 8;
      n = (active_cnt > NumLights) ? NumLights : active_cnt;
      lum = 0;
      for (int i = 0; i < n; i++) begin
        if (lights[i].radius == 0) continue;
        dx = cx - longint'(lights[i].x) * 16;
        dy = cy - longint'(lights[i].y) * 16;
        dist2 = dx * dx + dy * dy;
        lim = longint'(lights[i].radius) * 16;
        if (dist2 > lim * lim) continue;
        root = int_sqrt(dist2 << 32);
        ratio = root / lim;
        if (ratio > 65536) ratio = 65536;
        lum += ((65536 - ratio) * lights[i].strength + 128) >> 8;
      end
      if (lum > 65536) lum = 65536;
      return 8'((lum * 255 + 32768) >> 16);
    endfunction

    function void close_run(logic is_last);
      tlss_pkg::span_t s;
      s.span_row = open_row;
      s.span_start = open_start;
      s.span_length = open_len;
      s.span_shade = open_shade;
      s.last = is_last;
      spans_due.push_back(s);
    endfunction

    // Note an accepted word: update the table or advance the open run
    function void note_item(tlss_pkg::item_t it);
      logic [7:0] shade;
      if (it.cmd == tlss_pkg::CmdLoad) begin
        lights[it.light_index].x = it.light_x;
        lights[it.light_index].y = it.light_y;
        lights[it.light_index].radius = it.light_radius;
        lights[it.light_index].strength = it.light_strength;
        return;
      end
      shade = tile_shade(it.tile_col, it.tile_row);
      if (open_len != 0 && (it.tile_col == 0 || it.tile_row != open_row)) begin
        close_run(1'b1);
        open_len = 0;
      end
      if (open_len != 0 && shade == open_shade && open_len < 256) begin
        open_len++;
      end else begin
        if (open_len != 0) close_run(1'b0);
        open_row = it.tile_row;
        open_start = it.tile_col;
        open_len = 1;
        open_shade = shade;
      end
      if (it.row_end) begin
        close_run(1'b1);
        open_len = 0;
      end
    endfunction

    function void check_span(tlss_pkg::span_t got);
      tlss_pkg::span_t want;
      if (spans_due.size() == 0) begin
        $error("unexpected span word %p", got);
        errors++;
        return;
      end
      want = spans_due.pop_front();
      if (got.span_row !== want.span_row) begin
        $error("span_row expected %0d actual %0d", want.span_row, got.span_row);
        errors++;
      end
      if (got.span_start !== want.span_start) begin
        $error("span_start expected %0d actual %0d", want.span_start, got.span_start);
        errors++;
      end
      if (got.span_length !== want.span_length) begin
        $error("span_length expected %0d actual %0d", want.span_length, got.span_length);
        errors++;
      end
      if (got.span_shade !== want.span_shade) begin
        $error("span_shade expected %0d actual %0d", want.span_shade, got.span_shade);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("last expected %0d actual %0d", want.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  int   send_idle_pct;
  int   recv_stall_pct;
  int   quiet_cycles;

  tlss_in_if  in_if ();
  tlss_out_if out_if ();
  tlss_cfg_if cfg_if ();

  span_scoreboard sb = new();

  tile_light_shade_span_merge_unit dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_if (in_if),
    .out_if(out_if),
    .cfg_if(cfg_if)
  );

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  // Check span words and drive a randomly stalling ready
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) sb.check_span(out_if.data);
      out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog: end the run when no word moves for too long
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchLimit) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_word(tlss_pkg::item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data <= it;
    do @(posedge clk_i); while (!in_if.ready);
    sb.note_item(it);
  endtask

  // Hold valid between back to back writes; the caller drops it
  task automatic write_cfg(logic [1:0] idx, logic [15:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.wdata <= val;
    do @(posedge clk_i); while (!cfg_if.ready);
    sb.write_reg(idx, val);
  endtask

  // Hold the sender until every span is back and the block is quiet
  task automatic settle();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.spans_due.size() != 0) @(posedge clk_i);
    repeat (SettleCyc) @(posedge clk_i);
  endtask

  task automatic set_screen(logic [15:0] lx, logic [15:0] ty, logic [4:0] cnt);
    write_cfg(tlss_pkg::RegScreenLeft, lx);
    write_cfg(tlss_pkg::RegScreenTop, ty);
    write_cfg(tlss_pkg::RegLightCount, 16'(cnt));
    cfg_if.valid <= 1'b0;
  endtask

  function automatic tlss_pkg::item_t noise_bits();
    logic [95:0] raw;
    raw = {$urandom, $urandom, $urandom};
    return raw[$bits(tlss_pkg::item_t)-1:0];
  endfunction

  task automatic load_light(int idx, int lx, int ly, int rad, int str);
    tlss_pkg::item_t it;
    it = noise_bits();
    it.cmd = tlss_pkg::CmdLoad;
    it.light_index = 4'(idx);
    it.light_x = 16'(lx);
    it.light_y = 16'(ly);
    it.light_radius = 12'(rad);
    it.light_strength = 9'(str);
    send_word(it);
  endtask

  task automatic sample_tile(int col, int row, bit fin);
    tlss_pkg::item_t it;
    it = noise_bits();
    it.cmd = tlss_pkg::CmdSample;
    it.tile_col = 8'(col);
    it.tile_row = 8'(row);
    it.row_end = fin;
    send_word(it);
  endtask

  // Place a light near the lit area so that tiles get real shading
  task automatic load_near(int idx);
    int rad;
    int pick;
    pick = $urandom_range(99);
    rad = (pick < 5) ? 0 : (pick < 10) ? 4095 : $urandom_range(1, 250);
    load_light(idx, sb.left_px + $urandom_range(0, 420) - 30,
               sb.top_px + $urandom_range(0, 420) - 30, rad,
               ($urandom_range(9) == 0) ? $urandom_range(257, 511) : $urandom_range(0, 256));
  endtask

  // Mostly well-formed rows with random content, some loads and stray tiles
  task automatic random_phase(int words, int max_cnt);
    int sent;
    int pick;
    int row;
    int c0;
    int w;
    set_screen(16'($urandom_range(0, 400) - 200), 16'($urandom_range(0, 400) - 200),
               5'($urandom_range(1, max_cnt)));
    for (int i = 0; i < NumLights; i++) load_near(i);
    sent = NumLights;
    while (sent < words) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        load_near($urandom_range(0, NumLights - 1));
        sent++;
      end else if (pick < 16) begin
        sample_tile($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(1));
        sent++;
      end else begin
        row = $urandom_range(0, 30);
        c0 = ($urandom_range(9) < 7) ? 0 : $urandom_range(1, 255);
        w = $urandom_range(1, 24);
        for (int c = 0; c < w && c0 + c < 256; c++) begin
          sample_tile(c0 + c, row, (c == w - 1) && ($urandom_range(9) != 0));
          sent++;
        end
      end
    end
    settle();
  endtask

  initial begin
    rst_ni = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    quiet_cycles = 0;
    in_if.valid = 1'b0;
    in_if.data = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.wdata = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: fill the whole table, field extremes included
    set_screen(16'd0, 16'd0, 5'd0);
    load_light(0, 100, 100, 200, 256);
    load_light(1, -32768, 32767, 4095, 511);
    load_light(2, 32767, -32768, 4095, 256);
    load_light(3, 50, 50, 0, 256);
    load_light(4, 0, 0, 4095, 0);
    load_light(5, 40, 8, 30, 300);
    for (int i = 6; i < NumLights; i++) load_light(i, 8 + 16 * i, 8, 12, 200);

    // Directed with no lights: full span, stale runs, run with no start
    for (int c = 0; c < 256; c++) sample_tile(c, 3, 1'b0);
    sample_tile(7, 3, 1'b1);
    sample_tile(5, 4, 1'b0);
    sample_tile(6, 5, 1'b0);
    sample_tile(0, 5, 1'b0);
    sample_tile(1, 5, 1'b1);
    settle();

    // Directed: oversized light count and screen extremes
    set_screen(16'h8000, 16'h7fff, 5'd31);
    sample_tile(0, 0, 1'b0);
    sample_tile(255, 255, 1'b1);
    settle();
    set_screen(16'h7fff, 16'h8000, 5'd16);
    sample_tile(0, 255, 1'b0);
    sample_tile(255, 0, 1'b1);
    settle();
    set_screen(16'd0, 16'd0, 5'd16);
    for (int c = 0; c < 12; c++) sample_tile(c, 0, c == 11);
    settle();

    // Random phases under varying idling on both sides
    random_phase(300, 4);
    send_idle_pct = 78;
    random_phase(300, 3);
    send_idle_pct = 0;
    recv_stall_pct = 78;
    random_phase(300, 4);
    send_idle_pct = 14;
    recv_stall_pct = 14;
    random_phase(300, 4);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    random_phase(60, 16);

    if (sb.errors == 0 && sb.spans_due.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

/* filelist.f */
hdl/tlss_pkg.sv
hdl/tlss_if.sv
hdl/tlss_root_cell.sv
hdl/tlss_div_cell.sv
hdl/tile_light_shade_span_merge_unit.sv
test/tb_tile_light_shade_span_merge_unit.sv
